// File: rtl/core/wrm_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// wrm_pkg
// Shared types and constants for the dot/star whole-text matcher.
// ============================================================================
package wrm_pkg;

    // Item operation codes.
    typedef enum logic [1:0] {
        MODE_CLEAR   = 2'd0,
        MODE_APPEND  = 2'd1,
        MODE_TEXT    = 2'd2,
        MODE_VERDICT = 2'd3
    } mode_t;

    // Result error codes.
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW   = 2'd1;
    localparam logic [1:0] ERR_AFTER_TEXT = 2'd2;

    localparam logic [7:0] STAR_CHAR = 8'h2A;
    localparam logic [7:0] DOT_CHAR  = 8'h2E;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    // Operands for one column of the match row.
    typedef struct packed {
        logic [7:0] p;          // pattern byte of this column
        logic [7:0] q;          // pattern byte one column back
        logic       has_q;      // column index is two or more
        logic [7:0] c;          // text byte
        logic       old_cur;    // old row, this column
        logic       old_prev;   // old row, one column back
        logic       new_back2;  // new row, two columns back
    } col_in_t;

endpackage

// File: rtl/core/wrm_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// wrm_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module wrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/core/wrm_col.sv
`timescale 1ns / 1ps
// ============================================================================
// wrm_col
// Evaluates one column of the next match row from the pattern bytes around
// that column, the text byte and the neighboring row bits.
// ============================================================================
module wrm_col (
    input  wrm_pkg::col_in_t col_in,
    output logic             bit_out
);

    logic p_hit;
    logic q_hit;

    assign p_hit = (col_in.p == wrm_pkg::DOT_CHAR) || (col_in.p == col_in.c);
    assign q_hit = (col_in.q == wrm_pkg::DOT_CHAR) || (col_in.q == col_in.c);

    always_comb
    begin
        if (col_in.p == wrm_pkg::STAR_CHAR)
        begin
            // A star either drops its element or eats one more byte with it.
            // A leading star never matches.
            bit_out = col_in.has_q & (col_in.new_back2 | (q_hit & col_in.old_cur));
        end
        else
        begin
            bit_out = p_hit & col_in.old_prev;
        end
    end

endmodule

// File: rtl/core/wildcard_regex_match_dp.sv
`timescale 1ns / 1ps
// ============================================================================
// wildcard_regex_match_dp
// Whole-text matcher for patterns with '.' and '*', one text byte per item.
// ============================================================================
//
//  Channel | Signals                       | Direction | Purpose
//  --------+-------------------------------+-----------+------------------------
//  in      | in_valid in_ready mode char.  | input     | clear/append/text/verdict
//  out     | out_valid out_ready matched   | output    | verdict and error result
//          | error_code                    |           |
//
//  Clear, append and verdict items are handled as they are accepted. A text
//  item holds off new items while the pattern RAM, which has one read port,
//  is read so that the row is recomputed one pattern column per cycle.
//  Reset sets the match row to bit zero only and empties the pattern; the
//  pattern RAM itself is not cleared and needs no sweep.
//  A pending result stalls the next item only when out_ready is low.
// ============================================================================
module wildcard_regex_match_dp #(
    parameter int MAX_PATTERN = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] mode,
    input  logic [7:0] character,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       matched,
    output logic [1:0] error_code
);

    localparam int AW = $clog2(MAX_PATTERN);
    localparam int CW = $clog2(MAX_PATTERN + 1);
    localparam int RW = MAX_PATTERN + 1;

    wrm_pkg::state_t state_reg, state_next;
    wrm_pkg::mode_t  in_mode;

    logic [RW-1:0] row_reg, row_next;
    logic [RW-1:0] nrow_reg, nrow_next;
    logic [CW-1:0] len_reg, len_next;
    logic [CW-1:0] col_reg, col_next;
    logic          started_reg, started_next;
    logic [1:0]    sticky_reg, sticky_next;
    logic [7:0]    char_reg, char_next;
    logic [7:0]    q_reg, q_next;
    logic          out_valid_reg, out_valid_next;
    logic          matched_reg, matched_next;
    logic [1:0]    err_reg, err_next;

    logic          in_fire;
    logic          out_fire;
    logic [CW-1:0] len_inc;
    logic [CW-1:0] col_m2;
    logic          col_last;
    logic [1:0]    append_err;
    logic          append_bit;
    logic [RW-1:0] nrow_upd;

    logic          ram_we;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    wrm_pkg::col_in_t col_in;
    logic             col_bit;

    assign in_mode  = wrm_pkg::mode_t'(mode);
    assign in_fire  = in_valid & in_ready;
    assign out_fire = out_valid_reg & out_ready;
    assign len_inc  = len_reg + CW'(1);
    assign col_m2   = col_reg - CW'(2);
    assign col_last = (col_reg == len_reg);

    wrm_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PATTERN)
    ) u_pattern_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (len_reg[AW-1:0]),
        .wdata (character),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        col_in.p         = ram_rdata;
        col_in.q         = q_reg;
        col_in.has_q     = (col_reg >= CW'(2));
        col_in.c         = char_reg;
        col_in.old_cur   = row_reg[col_reg];
        col_in.old_prev  = row_reg[col_reg - CW'(1)];
        col_in.new_back2 = (col_reg >= CW'(2)) ? nrow_reg[col_m2] : 1'b0;
    end

    wrm_col u_col (
        .col_in  (col_in),
        .bit_out (col_bit)
    );

    always_comb
    begin
        if (started_reg)
        begin
            append_err = wrm_pkg::ERR_AFTER_TEXT;
        end
        else if (len_reg >= CW'(MAX_PATTERN))
        begin
            append_err = wrm_pkg::ERR_OVERFLOW;
        end
        else
        begin
            append_err = wrm_pkg::ERR_NONE;
        end
        // The empty-text row: a non-leading star may drop its element.
        append_bit = (character == wrm_pkg::STAR_CHAR) && (len_reg != '0)
                     && row_reg[len_reg - CW'(1)];
        nrow_upd = nrow_reg;
        nrow_upd[col_reg] = col_bit;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wrm_pkg::ST_IDLE:
            begin
                if (in_fire && in_mode == wrm_pkg::MODE_TEXT && len_reg != '0)
                begin
                    state_next = wrm_pkg::ST_SCAN;
                end
            end
            wrm_pkg::ST_SCAN:
            begin
                if (col_last)
                begin
                    state_next = wrm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wrm_pkg::ST_IDLE;
            end
        endcase
    end

    // Handshake and RAM controls.
    always_comb
    begin
        in_ready  = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        unique case (state_reg)
            wrm_pkg::ST_IDLE:
            begin
                in_ready = ~out_valid_reg | out_ready;
                ram_we   = in_fire && in_mode == wrm_pkg::MODE_APPEND
                           && append_err == wrm_pkg::ERR_NONE;
                ram_re   = in_fire && in_mode == wrm_pkg::MODE_TEXT;
            end
            wrm_pkg::ST_SCAN:
            begin
                ram_re    = ~col_last;
                ram_raddr = col_reg[AW-1:0];
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        row_next       = row_reg;
        nrow_next      = nrow_reg;
        len_next       = len_reg;
        col_next       = col_reg;
        started_next   = started_reg;
        sticky_next    = sticky_reg;
        char_next      = char_reg;
        q_next         = q_reg;
        out_valid_next = out_valid_reg & ~out_fire;
        matched_next   = matched_reg;
        err_next       = err_reg;

        if (state_reg == wrm_pkg::ST_SCAN)
        begin
            nrow_next = nrow_upd;
            q_next    = ram_rdata;
            col_next  = col_reg + CW'(1);
            if (col_last)
            begin
                row_next = nrow_upd;
            end
        end
        else if (in_fire)
        begin
            unique case (in_mode)
                wrm_pkg::MODE_CLEAR:
                begin
                    row_next     = RW'(1);
                    len_next     = '0;
                    started_next = 1'b0;
                    sticky_next  = wrm_pkg::ERR_NONE;
                end
                wrm_pkg::MODE_APPEND:
                begin
                    if (append_err != wrm_pkg::ERR_NONE)
                    begin
                        if (sticky_reg == wrm_pkg::ERR_NONE)
                        begin
                            sticky_next = append_err;
                        end
                        out_valid_next = 1'b1;
                        matched_next   = row_reg[len_reg];
                        err_next       = append_err;
                    end
                    else
                    begin
                        row_next[len_inc] = append_bit;
                        len_next          = len_inc;
                    end
                end
                wrm_pkg::MODE_TEXT:
                begin
                    started_next = 1'b1;
                    char_next    = character;
                    nrow_next    = '0;
                    col_next     = CW'(1);
                    if (len_reg == '0)
                    begin
                        // Any text fails an empty pattern.
                        row_next = '0;
                    end
                end
                wrm_pkg::MODE_VERDICT:
                begin
                    out_valid_next = 1'b1;
                    matched_next   = row_reg[len_reg];
                    err_next       = sticky_reg;
                end
                default:
                begin
                    out_valid_next = out_valid_reg & ~out_fire;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wrm_pkg::ST_IDLE;
            row_reg       <= RW'(1);
            len_reg       <= '0;
            col_reg       <= '0;
            started_reg   <= 1'b0;
            sticky_reg    <= wrm_pkg::ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            len_reg       <= len_next;
            col_reg       <= col_next;
            started_reg   <= started_next;
            sticky_reg    <= sticky_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nrow_reg    <= nrow_next;
        char_reg    <= char_next;
        q_reg       <= q_next;
        matched_reg <= matched_next;
        err_reg     <= err_next;
    end

    assign out_valid  = out_valid_reg;
    assign matched    = matched_reg;
    assign error_code = err_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= CW'(MAX_PATTERN))
        else $error("pattern length beyond capacity");

    a_scan_col: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == wrm_pkg::ST_SCAN |-> (col_reg != '0 && col_reg <= len_reg))
        else $error("scan column out of range");

    a_text_sets_started: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_mode == wrm_pkg::MODE_TEXT |=> started_reg)
        else $error("text item did not mark text started");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_mode == wrm_pkg::MODE_CLEAR |=> row_reg == RW'(1) && len_reg == '0)
        else $error("clear item left state behind");

endmodule
